// File: hw/rtl/bounded_stack_with_extremes_macros.svh
// Assertion macros for the bounded stack block.
// Included inside module bodies that have clk and rst_n in scope.
`ifndef BOUNDED_STACK_WITH_EXTREMES_MACROS_SVH
`define BOUNDED_STACK_WITH_EXTREMES_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BSTK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BSTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bstk_pkg.sv
// Shared constants for the bounded stack: field widths, action and status codes.
// No dependencies.
package bstk_pkg;

  localparam int WORD_W = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [WORD_W-1:0] word_t;

  // Request actions (six and seven are unused and ignored)
  localparam action_t ACT_PUSH  = 3'd0;
  localparam action_t ACT_POP   = 3'd1;
  localparam action_t ACT_PEEK  = 3'd2;
  localparam action_t ACT_CLEAR = 3'd3;
  localparam action_t ACT_MAX   = 3'd4;
  localparam action_t ACT_MIN   = 3'd5;

  // Result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_BADPEEK = 2'd3;

endpackage

// File: hw/rtl/bounded_stack_with_extremes.sv
// LIFO stack of signed 32-bit words, DEPTH entries, with peek and max/min scan.
// Depends on bstk_pkg and bounded_stack_with_extremes_macros.svh.
//
// Each request gives exactly one result. Push, pop, clear, the unused actions and
// every refused request produce their result in the output register in the cycle
// after acceptance. A peek in range first reads the memory, then loads the word
// into the output register. Maximum and minimum on a nonempty stack scan the
// entries: the words sit in a single-port-read synchronous memory and the scan reads
// one entry per cycle. The input is stalled while a peek or scan is in progress and
// while a finished result is held by a stalled output. The memory needs no clearing
// after reset; the block accepts requests at once.
module bounded_stack_with_extremes #(
  parameter int  DEPTH = 64,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bstk_pkg::action_t      in_action,
  input  logic signed [bstk_pkg::WORD_W-1:0] in_operand,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [bstk_pkg::WORD_W-1:0] out_data,
  output bstk_pkg::status_t      out_status,
  output logic [CNT_W-1:0]       out_count,
  output logic                   out_is_empty,
  output logic                   out_is_full
);
  import bstk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_PEEK, S_SCAN, S_DONE} state_t;

  // Controller state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             first_r, first_nxt;
  logic             want_max_r, want_max_nxt;
  word_t            best_r, best_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  word_t            out_data_r, out_data_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_full_r, out_full_nxt;

  // Memory ports
  word_t            mem [DEPTH];
  word_t            rdata_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  logic             in_acc;
  logic             out_free;
  logic [CNT_W-1:0] peek_idx;
  logic             peek_bad;
  logic             better;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Peek offset check: negative or not below the count fails
  assign peek_bad = (count_r == '0) || in_operand[WORD_W-1] ||
                    ({{(WORD_W-CNT_W){1'b0}}, count_r} <= $unsigned(in_operand));
  assign peek_idx = count_r - CNT_W'(1) - in_operand[CNT_W-1:0];

  // Scan compare against the running extreme
  assign better = want_max_r ? ($signed(rdata_r) > $signed(best_r))
                             : ($signed(rdata_r) < $signed(best_r));

  // Storage: one write port, one registered read port. A push writes in the
  // accept cycle; any read of that entry is issued later, so no forwarding.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_operand;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Next-state logic
  always_comb begin
    logic    emit;
    word_t   res_data;
    status_t res_status;

    emit         = 1'b0;
    res_data     = '0;
    res_status   = ST_OK;
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    first_nxt    = first_r;
    want_max_nxt = want_max_r;
    best_nxt     = best_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;

    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          emit = 1'b1;
          case (in_action)
            ACT_PUSH: begin
              if (count_r == FULL_CNT) begin
                res_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_PEEK: begin
              if (peek_bad) begin
                res_status = ST_BADPEEK;
              end else begin
                emit      = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = peek_idx[AW-1:0];
                state_nxt = S_PEEK;
              end
            end
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_MAX, ACT_MIN: begin
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                emit         = 1'b0;
                rd_en        = 1'b1;
                rd_addr      = '0;
                rd_idx_nxt   = CNT_W'(1);
                first_nxt    = 1'b1;
                want_max_nxt = (in_action == ACT_MAX);
                state_nxt    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_PEEK: begin
        // read data is held until the next read, so waiting is safe
        if (out_free) begin
          emit      = 1'b1;
          res_data  = rdata_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        best_nxt  = (first_r || better) ? rdata_r : best_r;
        first_nxt = 1'b0;
        if (rd_idx_r != count_r) begin
          rd_en      = 1'b1;
          rd_addr    = rd_idx_r[AW-1:0];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          res_data  = best_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the output register with the finished result
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = res_data;
      out_status_nxt = res_status;
      out_count_nxt  = count_nxt;
      out_empty_nxt  = (count_nxt == '0);
      out_full_nxt   = (count_nxt == FULL_CNT);
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    first_r      <= first_nxt;
    want_max_r   <= want_max_nxt;
    best_r       <= best_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = $signed(out_data_r);
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_empty_r;
  assign out_is_full  = out_full_r;

  // Checks
  `include "bounded_stack_with_extremes_macros.svh"

  `BSTK_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT, "entry count above capacity")
  `BSTK_ASSERT_NOW(a_full_flag, out_valid_r && (out_status_r == ST_FULL), out_full_r,
    "full status without full flag")
  `BSTK_ASSERT_NOW(a_empty_data, out_valid_r && (out_status_r == ST_EMPTY), out_data_r == '0,
    "empty status with nonzero data")
  `BSTK_ASSERT_NEXT(a_push_count,
    in_acc && (in_action == ACT_PUSH) && (count_r != FULL_CNT),
    count_r == $past(count_r) + CNT_W'(1), "push did not advance the count")

endmodule
